// ===== design/mmp_pkg.sv =====
// Shared widths, register codes and pipeline payload types for the
// Michaelis-Menten propensity block. No dependencies.
package mmp_pkg;

    // Count and fraction widths of the datapath
    localparam int COUNT_BITS = 24;
    localparam int FRAC_BITS  = 16;

    // Fixed port widths
    localparam int IN_W      = 24;
    localparam int CFG_W     = 32;
    localparam int PROP_W    = 48;
    localparam int SFO_W     = 40;
    localparam int CFG_IDX_W = 1;

    // Register indexes and reset value (1.0 in Q16.16)
    localparam logic [CFG_IDX_W-1:0] REG_KM   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KCAT = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_RESET = 32'h0001_0000;

    // Derived datapath widths
    localparam int SS_W   = COUNT_BITS + FRAC_BITS;
    localparam int BM_W   = ((SS_W > CFG_W) ? SS_W : CFG_W) + 1;
    localparam int KS_W   = CFG_W + SS_W;
    localparam int RAD_W  = ((2 * BM_W > KS_W + 2) ? 2 * BM_W : KS_W + 2) + 1;
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int RADP_W = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int SF_W   = ROOT_W;
    localparam int DV1_W  = ROOT_W + 1;
    localparam int N1_W   = KS_W + 1;
    localparam int Q1_W   = KS_W / 2 + 2;
    localparam int R1_W   = DV1_W + 1;
    localparam int DEN_W  = SF_W + 1;
    localparam int KE_W   = CFG_W + COUNT_BITS;
    localparam int NUM_W  = KE_W + SF_W;
    localparam int Q2_W   = PROP_W;
    localparam int R2_W   = DEN_W + 1;
    localparam int SFX_W  = (SF_W > SFO_W) ? SF_W : SFO_W;
    localparam int OVF_W  = ((NUM_W - Q2_W) > DEN_W) ? (NUM_W - Q2_W) : DEN_W;

    // Payload carried alongside the square root
    typedef struct packed {
        logic [COUNT_BITS-1:0] enz;
        logic [BM_W-1:0]       bmag;
        logic                  bneg;
        logic [KS_W-1:0]       ks;
    } root_side_t;

    // Payload carried alongside the root divider
    typedef struct packed {
        logic [COUNT_BITS-1:0] enz;
        logic [SF_W-1:0]       sf_alt;
        logic                  use_div;
    } div_side_t;

    // Payload carried alongside the propensity divider
    typedef struct packed {
        logic             zero;
        logic             ovf;
        logic [SFO_W-1:0] sf_out;
    } prop_side_t;

endpackage

// ===== design/mmp_front.sv =====
// Front end: count scaling, Km*S product, b magnitude and b^2 + 4*Km*S radicand.
// Depends on mmp_pkg.
module mmp_front
    import mmp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_s,
    input  logic [IN_W-1:0]   in_e,
    input  logic [CFG_W-1:0]  km,
    output logic              out_valid,
    output logic [RADP_W-1:0] out_rad,
    output root_side_t        out_side
);

    localparam int BH   = (BM_W + 1) / 2;
    localparam int HH_W = 2 * (BM_W - BH);
    localparam int KR_W = CFG_W + COUNT_BITS;

    // Drop count bits above COUNT_BITS
    logic [IN_W+COUNT_BITS-1:0] s_ext, e_ext;
    logic [COUNT_BITS-1:0]      s_cnt, e_cnt;
    assign s_ext = {{COUNT_BITS{1'b0}}, in_s};
    assign e_ext = {{COUNT_BITS{1'b0}}, in_e};
    assign s_cnt = s_ext[COUNT_BITS-1:0];
    assign e_cnt = e_ext[COUNT_BITS-1:0];

    // Stage 1: Km*S and Km + e
    logic                  v1_reg;
    logic [SS_W-1:0]       s1_reg;
    logic [COUNT_BITS-1:0] e1_reg;
    logic [KS_W-1:0]       ks1_reg;
    logic [BM_W-1:0]       neg1_reg;
    logic [KR_W-1:0]       ksraw_next;
    logic [BM_W-1:0]       neg1_next;

    assign ksraw_next = KR_W'(km) * KR_W'(s_cnt);
    assign neg1_next  = BM_W'(km) + BM_W'({e_cnt, {FRAC_BITS{1'b0}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg   <= {s_cnt, {FRAC_BITS{1'b0}}};
            e1_reg   <= e_cnt;
            ks1_reg  <= {ksraw_next, {FRAC_BITS{1'b0}}};
            neg1_reg <= neg1_next;
        end
    end

    // Stage 2: sign and magnitude of b = s - Km - e
    logic                  v2_reg;
    logic [COUNT_BITS-1:0] e2_reg;
    logic [KS_W-1:0]       ks2_reg;
    logic                  bneg2_reg;
    logic [BM_W-1:0]       bmag2_reg;
    logic                  bneg2_next;
    logic [BM_W-1:0]       bmag2_next;

    always_comb begin
        bneg2_next = neg1_reg > BM_W'(s1_reg);
        if (bneg2_next) begin
            bmag2_next = neg1_reg - BM_W'(s1_reg);
        end else begin
            bmag2_next = BM_W'(s1_reg) - neg1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e2_reg    <= e1_reg;
            ks2_reg   <= ks1_reg;
            bneg2_reg <= bneg2_next;
            bmag2_reg <= bmag2_next;
        end
    end

    // Stage 3: partial products of b^2
    logic                  v3_reg;
    root_side_t            side3_reg;
    logic [2*BH-1:0]       pp_ll_reg;
    logic [BM_W-1:0]       pp_hl_reg;
    logic [HH_W-1:0]       pp_hh_reg;
    logic [BH-1:0]         b_lo;
    logic [BM_W-BH-1:0]    b_hi;

    assign b_lo = bmag2_reg[BH-1:0];
    assign b_hi = bmag2_reg[BM_W-1:BH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_ll_reg      <= (2*BH)'(b_lo) * (2*BH)'(b_lo);
            pp_hl_reg      <= BM_W'(b_hi) * BM_W'(b_lo);
            pp_hh_reg      <= HH_W'(b_hi) * HH_W'(b_hi);
            side3_reg.enz  <= e2_reg;
            side3_reg.bmag <= bmag2_reg;
            side3_reg.bneg <= bneg2_reg;
            side3_reg.ks   <= ks2_reg;
        end
    end

    // Stage 4: radicand b^2 + 4*Km*s
    logic              v4_reg;
    logic [RADP_W-1:0] rad4_reg;
    root_side_t        side4_reg;
    logic [RADP_W-1:0] rad4_next;

    assign rad4_next = (RADP_W'(pp_hh_reg) << (2 * BH))
                     + (RADP_W'(pp_hl_reg) << (BH + 1))
                     + RADP_W'(pp_ll_reg)
                     + (RADP_W'(side3_reg.ks) << 2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad4_reg  <= rad4_next;
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_rad   = rad4_reg;
    assign out_side  = side4_reg;

endmodule

// ===== design/mmp_sqrt.sv =====
// Pipelined restoring integer square root, one root bit per stage.
// Depends on mmp_pkg.
module mmp_sqrt
    import mmp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RADP_W-1:0] in_rad,
    input  root_side_t        in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output root_side_t        out_side
);

    logic              v_reg    [ROOT_W];
    logic [RADP_W-1:0] rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    root_side_t        side_reg [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        logic              vi;
        logic [RADP_W-1:0] radi;
        logic [REM_W-1:0]  remi;
        logic [ROOT_W-1:0] rooti;
        root_side_t        sidei;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  tval;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (j == 0) begin : g_head
            assign vi    = in_valid;
            assign radi  = in_rad;
            assign remi  = '0;
            assign rooti = '0;
            assign sidei = in_side;
        end else begin : g_body
            assign vi    = v_reg[j-1];
            assign radi  = rad_reg[j-1];
            assign remi  = rem_reg[j-1];
            assign rooti = root_reg[j-1];
            assign sidei = side_reg[j-1];
        end

        // Bring down the next bit pair and try root*4 + 1
        always_comb begin
            trial = {remi[REM_W-3:0], radi[RADP_W-1-2*j -: 2]};
            tval  = {rooti, 2'b01};
            if (trial >= tval) begin
                rem_next  = trial - tval;
                root_next = {rooti[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                root_next = {rooti[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[j]  <= radi;
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                side_reg[j] <= sidei;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== design/mmp_rdiv.sv =====
// Free substrate: stable-root divider 2*Km*s / (disc + |b|) and root form select.
// Depends on mmp_pkg.
module mmp_rdiv
    import mmp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [ROOT_W-1:0]     in_root,
    input  root_side_t            in_side,
    output logic                  out_valid,
    output logic [SF_W-1:0]       out_sfree,
    output logic [COUNT_BITS-1:0] out_enz
);

    // Entry stage: dividend, divisor and the plain root form
    logic             ve_reg;
    logic [Q1_W-1:0]  nlo_e_reg;
    logic [DV1_W-1:0] d_e_reg;
    logic [R1_W-1:0]  rem_e_reg;
    div_side_t        side_e_reg;
    logic [N1_W-1:0]  n_next;
    logic [DV1_W-1:0] d_next;
    div_side_t        side_next;

    always_comb begin
        n_next            = {in_side.ks, 1'b0};
        d_next            = DV1_W'(in_root) + DV1_W'(in_side.bmag);
        side_next.enz     = in_side.enz;
        side_next.use_div = in_side.bneg && (in_side.ks != '0);
        if (!in_side.bneg) begin
            side_next.sf_alt = SF_W'(d_next >> 1);
        end else if (in_root > ROOT_W'(in_side.bmag)) begin
            side_next.sf_alt = SF_W'((in_root - ROOT_W'(in_side.bmag)) >> 1);
        end else begin
            side_next.sf_alt = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
        end else if (en) begin
            ve_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nlo_e_reg  <= n_next[Q1_W-1:0];
            d_e_reg    <= d_next;
            rem_e_reg  <= R1_W'(n_next >> Q1_W);
            side_e_reg <= side_next;
        end
    end

    // Restoring divide, one quotient bit per stage
    logic             v_reg    [Q1_W];
    logic [Q1_W-1:0]  nlo_reg  [Q1_W];
    logic [DV1_W-1:0] d_reg    [Q1_W];
    logic [R1_W-1:0]  rem_reg  [Q1_W];
    logic [Q1_W-1:0]  q_reg    [Q1_W];
    div_side_t        side_reg [Q1_W];

    for (genvar j = 0; j < Q1_W; j++) begin : g_stage
        logic             vi;
        logic [Q1_W-1:0]  nloi;
        logic [DV1_W-1:0] di;
        logic [R1_W-1:0]  remi;
        logic [Q1_W-1:0]  qi;
        div_side_t        sidei;
        logic [R1_W-1:0]  trial;
        logic [R1_W-1:0]  rem_next;
        logic [Q1_W-1:0]  q_next;

        if (j == 0) begin : g_head
            assign vi    = ve_reg;
            assign nloi  = nlo_e_reg;
            assign di    = d_e_reg;
            assign remi  = rem_e_reg;
            assign qi    = '0;
            assign sidei = side_e_reg;
        end else begin : g_body
            assign vi    = v_reg[j-1];
            assign nloi  = nlo_reg[j-1];
            assign di    = d_reg[j-1];
            assign remi  = rem_reg[j-1];
            assign qi    = q_reg[j-1];
            assign sidei = side_reg[j-1];
        end

        always_comb begin
            trial = {remi[R1_W-2:0], nloi[Q1_W-1-j]};
            if (trial >= R1_W'(di)) begin
                rem_next = trial - R1_W'(di);
                q_next   = {qi[Q1_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {qi[Q1_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nlo_reg[j]  <= nloi;
                d_reg[j]    <= di;
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
                side_reg[j] <= sidei;
            end
        end
    end

    // Select the root form
    logic                  vo_reg;
    logic [SF_W-1:0]       sf_o_reg;
    logic [COUNT_BITS-1:0] enz_o_reg;
    logic [SF_W-1:0]       sf_o_next;

    assign sf_o_next = side_reg[Q1_W-1].use_div ? SF_W'(q_reg[Q1_W-1])
                                                : side_reg[Q1_W-1].sf_alt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v_reg[Q1_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sf_o_reg  <= sf_o_next;
            enz_o_reg <= side_reg[Q1_W-1].enz;
        end
    end

    assign out_valid = vo_reg;
    assign out_sfree = sf_o_reg;
    assign out_enz   = enz_o_reg;

endmodule

// ===== design/mmp_pdiv.sv =====
// Propensity: kcat*E*sFree product, divide by Km + sFree, saturate, output register.
// Depends on mmp_pkg.
module mmp_pdiv
    import mmp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [SF_W-1:0]       in_sfree,
    input  logic [COUNT_BITS-1:0] in_enz,
    input  logic [CFG_W-1:0]      km,
    input  logic [CFG_W-1:0]      kcat,
    output logic                  out_valid,
    output logic [PROP_W-1:0]     out_prop,
    output logic [SFO_W-1:0]      out_sfree
);

    localparam int KH    = (KE_W + 1) / 2;
    localparam int SH    = (SF_W + 1) / 2;
    localparam int LL_W  = KH + SH;
    localparam int HL_W  = KE_W - KH + SH;
    localparam int LH_W  = KH + SF_W - SH;
    localparam int HHP_W = KE_W - KH + SF_W - SH;

    // P1: kcat*E, denominator, saturated sFree field
    logic             v1_reg;
    logic [KE_W-1:0]  ke1_reg;
    logic [DEN_W-1:0] den1_reg;
    logic [SF_W-1:0]  sf1_reg;
    logic [SFO_W-1:0] sfo1_reg;
    logic [SFX_W-1:0] sfx;
    logic [SFO_W-1:0] sfo_next;

    always_comb begin
        sfx = SFX_W'(in_sfree);
        if ((sfx >> SFO_W) != '0) begin
            sfo_next = '1;
        end else begin
            sfo_next = sfx[SFO_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ke1_reg  <= KE_W'(kcat) * KE_W'(in_enz);
            den1_reg <= DEN_W'(km) + DEN_W'(in_sfree);
            sf1_reg  <= in_sfree;
            sfo1_reg <= sfo_next;
        end
    end

    // P2: partial products of kcat*E*sFree
    logic             v2_reg;
    logic [LL_W-1:0]  p_ll_reg;
    logic [HL_W-1:0]  p_hl_reg;
    logic [LH_W-1:0]  p_lh_reg;
    logic [HHP_W-1:0] p_hh_reg;
    logic [DEN_W-1:0] den2_reg;
    logic [SFO_W-1:0] sfo2_reg;
    logic [KH-1:0]        k_lo;
    logic [KE_W-KH-1:0]   k_hi;
    logic [SH-1:0]        f_lo;
    logic [SF_W-SH-1:0]   f_hi;

    assign k_lo = ke1_reg[KH-1:0];
    assign k_hi = ke1_reg[KE_W-1:KH];
    assign f_lo = sf1_reg[SH-1:0];
    assign f_hi = sf1_reg[SF_W-1:SH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_ll_reg <= LL_W'(k_lo) * LL_W'(f_lo);
            p_hl_reg <= HL_W'(k_hi) * HL_W'(f_lo);
            p_lh_reg <= LH_W'(k_lo) * LH_W'(f_hi);
            p_hh_reg <= HHP_W'(k_hi) * HHP_W'(f_hi);
            den2_reg <= den1_reg;
            sfo2_reg <= sfo1_reg;
        end
    end

    // P3: sum the partial products
    logic             v3_reg;
    logic [NUM_W-1:0] num3_reg;
    logic [DEN_W-1:0] den3_reg;
    logic [SFO_W-1:0] sfo3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num3_reg <= NUM_W'(p_ll_reg)
                      + (NUM_W'(p_hl_reg) << KH)
                      + (NUM_W'(p_lh_reg) << SH)
                      + (NUM_W'(p_hh_reg) << (KH + SH));
            den3_reg <= den2_reg;
            sfo3_reg <= sfo2_reg;
        end
    end

    // P4: divider entry, flag a zero denominator and a quotient too wide
    logic             ve_reg;
    logic [Q2_W-1:0]  nlo_e_reg;
    logic [DEN_W-1:0] d_e_reg;
    logic [R2_W-1:0]  rem_e_reg;
    prop_side_t       side_e_reg;
    prop_side_t       side_e_next;

    always_comb begin
        side_e_next.zero   = den3_reg == '0;
        side_e_next.ovf    = OVF_W'(num3_reg >> Q2_W) >= OVF_W'(den3_reg);
        side_e_next.sf_out = sfo3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
        end else if (en) begin
            ve_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nlo_e_reg  <= num3_reg[Q2_W-1:0];
            d_e_reg    <= den3_reg;
            rem_e_reg  <= R2_W'(num3_reg >> Q2_W);
            side_e_reg <= side_e_next;
        end
    end

    // Restoring divide, one quotient bit per stage
    logic             v_reg    [Q2_W];
    logic [Q2_W-1:0]  nlo_reg  [Q2_W];
    logic [DEN_W-1:0] d_reg    [Q2_W];
    logic [R2_W-1:0]  rem_reg  [Q2_W];
    logic [Q2_W-1:0]  q_reg    [Q2_W];
    prop_side_t       side_reg [Q2_W];

    for (genvar j = 0; j < Q2_W; j++) begin : g_stage
        logic             vi;
        logic [Q2_W-1:0]  nloi;
        logic [DEN_W-1:0] di;
        logic [R2_W-1:0]  remi;
        logic [Q2_W-1:0]  qi;
        prop_side_t       sidei;
        logic [R2_W-1:0]  trial;
        logic [R2_W-1:0]  rem_next;
        logic [Q2_W-1:0]  q_next;

        if (j == 0) begin : g_head
            assign vi    = ve_reg;
            assign nloi  = nlo_e_reg;
            assign di    = d_e_reg;
            assign remi  = rem_e_reg;
            assign qi    = '0;
            assign sidei = side_e_reg;
        end else begin : g_body
            assign vi    = v_reg[j-1];
            assign nloi  = nlo_reg[j-1];
            assign di    = d_reg[j-1];
            assign remi  = rem_reg[j-1];
            assign qi    = q_reg[j-1];
            assign sidei = side_reg[j-1];
        end

        always_comb begin
            trial = {remi[R2_W-2:0], nloi[Q2_W-1-j]};
            if (trial >= R2_W'(di)) begin
                rem_next = trial - R2_W'(di);
                q_next   = {qi[Q2_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {qi[Q2_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nlo_reg[j]  <= nloi;
                d_reg[j]    <= di;
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
                side_reg[j] <= sidei;
            end
        end
    end

    // Output register: zero denominator gives 0, a wide quotient saturates
    logic              vo_reg;
    logic [PROP_W-1:0] prop_o_reg;
    logic [SFO_W-1:0]  sfo_o_reg;
    logic [PROP_W-1:0] prop_o_next;

    always_comb begin
        if (side_reg[Q2_W-1].zero) begin
            prop_o_next = '0;
        end else if (side_reg[Q2_W-1].ovf) begin
            prop_o_next = '1;
        end else begin
            prop_o_next = q_reg[Q2_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v_reg[Q2_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prop_o_reg <= prop_o_next;
            sfo_o_reg  <= side_reg[Q2_W-1].sf_out;
        end
    end

    assign out_valid = vo_reg;
    assign out_prop  = prop_o_reg;
    assign out_sfree = sfo_o_reg;

endmodule

// ===== design/michaelis_menten_propensity.sv =====
// Michaelis-Menten propensity block: configuration registers, pipeline wiring, checks.
// Depends on mmp_pkg, mmp_front, mmp_sqrt, mmp_rdiv and mmp_pdiv.
//
// Takes one (substrate, enzyme) count request per clock, unless a result waits
// at the output, and returns the free substrate root and the propensity
// kcat*sFree*E/(Km + sFree); the pipeline is made of the front end, the
// bit-serial square root stages and the two restoring divider pipelines. The
// whole pipeline holds while a result waits at the output and advances
// otherwise, so throughput is one request per clock with a ready downstream.
// Km and kcat are to be written through the configuration port only while no
// request is in flight; the block itself does not enforce this.
module michaelis_menten_propensity
    import mmp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IN_W-1:0]      s_substrate_count,
    input  logic [IN_W-1:0]      s_enzyme_count,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PROP_W-1:0]    m_propensity,
    output logic [SFO_W-1:0]     m_free_substrate
);

    // Configuration registers
    logic [CFG_W-1:0] km_reg;
    logic [CFG_W-1:0] kcat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            km_reg   <= CFG_RESET;
            kcat_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KM: begin
                    km_reg <= cfg_wdata;
                end
                REG_KCAT: begin
                    kcat_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Advance the pipeline unless a result waits
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic                  fr_valid;
    logic [RADP_W-1:0]     fr_rad;
    root_side_t            fr_side;
    logic                  sq_valid;
    logic [ROOT_W-1:0]     sq_root;
    root_side_t            sq_side;
    logic                  rd_valid;
    logic [SF_W-1:0]       rd_sfree;
    logic [COUNT_BITS-1:0] rd_enz;

    mmp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_s      (s_substrate_count),
        .in_e      (s_enzyme_count),
        .km        (km_reg),
        .out_valid (fr_valid),
        .out_rad   (fr_rad),
        .out_side  (fr_side)
    );

    mmp_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_rad    (fr_rad),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    mmp_rdiv u_rdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_side   (sq_side),
        .out_valid (rd_valid),
        .out_sfree (rd_sfree),
        .out_enz   (rd_enz)
    );

    mmp_pdiv u_pdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rd_valid),
        .in_sfree  (rd_sfree),
        .in_enz    (rd_enz),
        .km        (km_reg),
        .kcat      (kcat_reg),
        .out_valid (m_valid),
        .out_prop  (m_propensity),
        .out_sfree (m_free_substrate)
    );

`ifndef SYNTHESIS
    // No free substrate means no propensity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_free_substrate == '0) |-> (m_propensity == '0))
        else $error("propensity nonzero with zero free substrate");

    // Reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Requests are refused only while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a waiting result");
`endif

endmodule

// ===== tb/mmp_checker.sv =====
// Scoreboard for the Michaelis-Menten propensity block: predicts each result
// from the accepted request and the current Km/kcat. Depends on mmp_pkg.
module mmp_checker
    import mmp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [IN_W-1:0]      s_substrate_count,
    input  logic [IN_W-1:0]      s_enzyme_count,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [PROP_W-1:0]    m_propensity,
    input  logic [SFO_W-1:0]     m_free_substrate,
    output int                   pending,
    output int                   errors
);

    typedef struct packed {
        logic [PROP_W-1:0] prop;
        logic [SFO_W-1:0]  sfree;
    } rate_t;

    localparam logic [127:0] MAX64 = {64'd0, {64{1'b1}}};

    rate_t               rate_q[$];
    logic [CFG_W-1:0]    km;
    logic [CFG_W-1:0]    kcat;

    // Exact fixed-point rate: stable quadratic root, then saturating division
    function automatic rate_t mm_rate(input logic [IN_W-1:0] sub, input logic [IN_W-1:0] enz,
                                      input logic [CFG_W-1:0] k, input logic [CFG_W-1:0] kc);
        logic [127:0] s, e, neg, bmag, ks, rad, disc, t, sf, den, num, q;
        logic         bneg;
        rate_t        r;
        s    = 128'(sub[COUNT_BITS-1:0]) << FRAC_BITS;
        e    = 128'(enz[COUNT_BITS-1:0]) << FRAC_BITS;
        neg  = 128'(k) + e;
        bneg = neg > s;
        bmag = bneg ? neg - s : s - neg;
        ks   = 128'(k) * s;
        rad  = bmag * bmag + (ks << 2);
        disc = '0;
        for (int i = 63; i >= 0; i--) begin
            t = disc | (128'd1 << i);
            if (t * t <= rad) disc = t;
        end
        if (bneg && ks != 0) begin
            q  = (ks << 1) / (disc + bmag);
            sf = (q > MAX64) ? MAX64 : q;
        end else if (!bneg) begin
            sf = (bmag >> 1) + (disc >> 1) + (bmag & disc & 128'd1);
        end else begin
            sf = (disc > bmag) ? (disc - bmag) >> 1 : '0;
        end
        den = 128'(k) + sf;
        if (den > MAX64) den = MAX64;
        if (den == 0) begin
            q = '0;
        end else begin
            num = 128'(kc) * 128'(enz[COUNT_BITS-1:0]) * sf;
            q   = num / den;
            if (q > MAX64) q = MAX64;
        end
        r.prop  = (q >= (128'd1 << PROP_W)) ? {PROP_W{1'b1}} : q[PROP_W-1:0];
        r.sfree = (sf >= (128'd1 << SFO_W)) ? {SFO_W{1'b1}} : sf[SFO_W-1:0];
        return r;
    endfunction

    assign pending = rate_q.size();

    // Track registers, queue predictions, compare results
    always @(posedge aclk) begin
        rate_t exp_r;
        if (!aresetn) begin
            km   <= CFG_RESET;
            kcat <= CFG_RESET;
            rate_q.delete();
            errors = 0;
        end else begin
            if (s_valid && s_ready)
                rate_q = {rate_q, mm_rate(s_substrate_count, s_enzyme_count, km, kcat)};
            if (m_valid && m_ready) begin
                if (rate_q.size() == 0) begin
                    $error("unexpected result: propensity %0h free_substrate %0h",
                           m_propensity, m_free_substrate);
                    errors++;
                end else begin
                    exp_r = rate_q.pop_front();
                    if (m_propensity !== exp_r.prop) begin
                        $error("propensity: expected %0h, got %0h", exp_r.prop, m_propensity);
                        errors++;
                    end
                    if (m_free_substrate !== exp_r.sfree) begin
                        $error("free_substrate: expected %0h, got %0h",
                               exp_r.sfree, m_free_substrate);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_KM:   km   <= cfg_wdata;
                    REG_KCAT: kcat <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the propensity regression: clock, reset, stimulus and verdict.
// Depends on mmp_pkg, michaelis_menten_propensity and mmp_checker.
module testbench;
    import mmp_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_KM;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [IN_W-1:0]      s_substrate_count = '0;
    logic [IN_W-1:0]      s_enzyme_count = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PROP_W-1:0]    m_propensity;
    logic [SFO_W-1:0]     m_free_substrate;
    int                   pending;
    int                   errors;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int hold_left = 0;

    michaelis_menten_propensity dut (.*);
    mmp_checker chk (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Drive the result side: long hold when asked, else random backpressure, or always ready while rx_idle is clear
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= rx_idle ? ($urandom_range(99) >= 19) : 1'b1;
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_request(input logic [IN_W-1:0] sub, input logic [IN_W-1:0] enz);
        while (tx_idle && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_substrate_count <= sub;
        s_enzyme_count    <= enz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and wait for every result to drain
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Present one register write for a single edge; the caller drops the enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Mostly counts near Km, sometimes full range
    task automatic random_requests(input int n);
        logic [IN_W-1:0] sub, enz;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: begin
                    sub = IN_W'($urandom);
                    enz = IN_W'($urandom);
                end
                1: begin
                    sub = IN_W'($urandom_range(20));
                    enz = IN_W'($urandom_range(20));
                end
                2: begin
                    sub = IN_W'($urandom_range(5000));
                    enz = IN_W'($urandom);
                end
                default: begin
                    sub = IN_W'($urandom_range(100000));
                    enz = IN_W'($urandom_range(2000));
                end
            endcase
            send_request(sub, enz);
        end
    endtask

    task automatic edge_requests();
        send_request(24'd0, 24'd0);
        send_request(24'hFFFFFF, 24'hFFFFFF);
        send_request(24'd0, 24'hFFFFFF);
        send_request(24'hFFFFFF, 24'd0);
        send_request(24'd1, 24'd1);
        send_request(24'd1, 24'd0);
        send_request(24'd0, 24'd1);
        send_request(24'hAAAAAA, 24'h555555);
        send_request(24'h555555, 24'hAAAAAA);
    endtask

    initial begin
        logic [CFG_W-1:0] km_set[6]   = '{32'h0001_0000, 32'd0, 32'hFFFF_FFFF,
                                          32'd0, 32'h0001_0000, 32'd0};
        logic [CFG_W-1:0] kcat_set[6] = '{32'h0001_0000, 32'd0, 32'hFFFF_FFFF,
                                          32'h0001_0000, 32'hFFFF_FFFF, 32'd0};
        km_set[5]   = $urandom;
        kcat_set[5] = $urandom;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values first, then each register setting
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                drain();
                write_reg(REG_KM, km_set[ph]);
                write_reg(REG_KCAT, kcat_set[ph]);
                cfg_wr_en <= 1'b0;
            end
            edge_requests();
            tx_idle = (ph != 2);
            rx_idle = (ph != 2);
            if (ph == 3) begin
                // Stall the output long enough to back up the pipeline
                tx_idle   = 1'b0;
                hold_left = 400;
            end
            random_requests(133);
            tx_idle = 1'b1;
            rx_idle = 1'b1;
        end

        drain();
        repeat (150) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("michaelis_menten_propensity regression: pass");
        end else begin
            $display("michaelis_menten_propensity regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("michaelis_menten_propensity regression: fail");
        $finish;
    end

endmodule
